// ===== src/gtl_pkg.sv =====
// Shared types, byte codes and the Greek-to-Latin lookup table.
// Used by the front end, the job queue and the output sequencer.
package gtl_pkg;

  localparam logic [7:0] NUL        = 8'h00;
  localparam logic [7:0] TBL_BASE   = 8'd182;

  // Letters that may be held back or that merge with a held letter
  localparam logic [7:0] BYTE_N_LO  = 8'd237;
  localparam logic [7:0] BYTE_N_UP  = 8'd205;
  localparam logic [7:0] BYTE_M_LO  = 8'd236;
  localparam logic [7:0] BYTE_M_UP  = 8'd204;
  localparam logic [7:0] BYTE_T_LO  = 8'd244;
  localparam logic [7:0] BYTE_T_UP  = 8'd212;
  localparam logic [7:0] BYTE_P_LO  = 8'd240;
  localparam logic [7:0] BYTE_P_UP  = 8'd208;

  localparam int unsigned JOB_CHARS = 4;

  // Lookup result: up to three characters, first in ch[0]
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] ch;
  } xlat_t;

  // One classified input: 1 to 4 characters to send, first in ch[0]
  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] ch;
    logic [2:0]                cnt;
  } job_t;

  function automatic xlat_t mk(logic [1:0] len, logic [7:0] c0, logic [7:0] c1,
                               logic [7:0] c2);
    xlat_t r;
    r.len   = len;
    r.ch[0] = c0;
    r.ch[1] = c1;
    r.ch[2] = c2;
    return r;
  endfunction

  // Map one byte to its Latin string; holes and 255 map to nothing
  function automatic xlat_t xlat_lookup(logic [7:0] b);
    xlat_t r;
    if (b < TBL_BASE) begin
      r = mk(2'd1, b, NUL, NUL);
    end else begin
      case (b)
        8'd182: r = mk(2'd2, "'", "A", NUL);
        8'd184: r = mk(2'd2, "'", "E", NUL);
        8'd185: r = mk(2'd2, "'", "H", NUL);
        8'd186: r = mk(2'd2, "'", "I", NUL);
        8'd188: r = mk(2'd2, "'", "O", NUL);
        8'd190: r = mk(2'd2, "'", "Y", NUL);
        8'd191: r = mk(2'd2, "'", "W", NUL);
        8'd192: r = mk(2'd3, "i", "\"", "'");
        8'd193: r = mk(2'd1, "A", NUL, NUL);
        8'd194: r = mk(2'd1, "V", NUL, NUL);
        8'd195: r = mk(2'd1, "G", NUL, NUL);
        8'd196: r = mk(2'd1, "D", NUL, NUL);
        8'd197: r = mk(2'd1, "E", NUL, NUL);
        8'd198: r = mk(2'd1, "Z", NUL, NUL);
        8'd199: r = mk(2'd1, "H", NUL, NUL);
        8'd200: r = mk(2'd1, "8", NUL, NUL);
        8'd201: r = mk(2'd1, "I", NUL, NUL);
        8'd202: r = mk(2'd1, "K", NUL, NUL);
        8'd203: r = mk(2'd1, "L", NUL, NUL);
        8'd204: r = mk(2'd1, "M", NUL, NUL);
        8'd205: r = mk(2'd1, "N", NUL, NUL);
        8'd206: r = mk(2'd2, "K", "S", NUL);
        8'd207: r = mk(2'd1, "O", NUL, NUL);
        8'd208: r = mk(2'd1, "P", NUL, NUL);
        8'd209: r = mk(2'd1, "R", NUL, NUL);
        8'd211: r = mk(2'd1, "S", NUL, NUL);
        8'd212: r = mk(2'd1, "T", NUL, NUL);
        8'd213: r = mk(2'd1, "Y", NUL, NUL);
        8'd214: r = mk(2'd1, "F", NUL, NUL);
        8'd215: r = mk(2'd1, "X", NUL, NUL);
        8'd216: r = mk(2'd2, "P", "S", NUL);
        8'd217: r = mk(2'd1, "W", NUL, NUL);
        8'd218: r = mk(2'd2, "I", "\"", NUL);
        8'd219: r = mk(2'd2, "Y", "\"", NUL);
        8'd220: r = mk(2'd2, "a", "'", NUL);
        8'd221: r = mk(2'd2, "e", "'", NUL);
        8'd222: r = mk(2'd2, "h", "'", NUL);
        8'd223: r = mk(2'd2, "i", "'", NUL);
        8'd224: r = mk(2'd3, "y", "\"", "'");
        8'd225: r = mk(2'd1, "a", NUL, NUL);
        8'd226: r = mk(2'd1, "v", NUL, NUL);
        8'd227: r = mk(2'd1, "g", NUL, NUL);
        8'd228: r = mk(2'd1, "d", NUL, NUL);
        8'd229: r = mk(2'd1, "e", NUL, NUL);
        8'd230: r = mk(2'd1, "z", NUL, NUL);
        8'd231: r = mk(2'd1, "h", NUL, NUL);
        8'd232: r = mk(2'd1, "8", NUL, NUL);
        8'd233: r = mk(2'd1, "i", NUL, NUL);
        8'd234: r = mk(2'd1, "k", NUL, NUL);
        8'd235: r = mk(2'd1, "l", NUL, NUL);
        8'd236: r = mk(2'd1, "m", NUL, NUL);
        8'd237: r = mk(2'd1, "n", NUL, NUL);
        8'd238: r = mk(2'd2, "k", "s", NUL);
        8'd239: r = mk(2'd1, "o", NUL, NUL);
        8'd240: r = mk(2'd1, "p", NUL, NUL);
        8'd241: r = mk(2'd1, "r", NUL, NUL);
        8'd242: r = mk(2'd1, "s", NUL, NUL);
        8'd243: r = mk(2'd1, "s", NUL, NUL);
        8'd244: r = mk(2'd1, "t", NUL, NUL);
        8'd245: r = mk(2'd1, "y", NUL, NUL);
        8'd246: r = mk(2'd1, "f", NUL, NUL);
        8'd247: r = mk(2'd1, "x", NUL, NUL);
        8'd248: r = mk(2'd2, "p", "s", NUL);
        8'd249: r = mk(2'd1, "w", NUL, NUL);
        8'd250: r = mk(2'd2, "i", "\"", NUL);
        8'd251: r = mk(2'd2, "y", "\"", NUL);
        8'd252: r = mk(2'd2, "o", "'", NUL);
        8'd253: r = mk(2'd2, "y", "'", NUL);
        8'd254: r = mk(2'd2, "w", "'", NUL);
        default: r = mk(2'd0, NUL, NUL, NUL);
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/gtl_front.sv =====
// Front end: accepts input words, tracks the held-back letter and
// turns each word into a job of output characters. Depends on gtl_pkg.
module gtl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_input_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output gtl_pkg::job_t q_job_o
);

  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_N_LO = 3'd1,
    PEND_N_UP = 3'd2,
    PEND_M_LO = 3'd3,
    PEND_M_UP = 3'd4
  } pend_e;

  pend_e              pend_q, pend_d;
  gtl_pkg::xlat_t     tx;
  logic               rel, use_tx, single, has_p, relo, accept;
  logic [7:0]         sch, pch;
  logic [1:0]         tl;
  gtl_pkg::job_t      job;

  // Character of the held letter
  always_comb begin
    has_p = 1'b1;
    case (pend_q)
      PEND_N_LO: pch = "n";
      PEND_N_UP: pch = "N";
      PEND_M_LO: pch = "m";
      PEND_M_UP: pch = "M";
      default: begin
        pch   = gtl_pkg::NUL;
        has_p = 1'b0;
      end
    endcase
  end

  // Classify the word and decide the next held letter
  always_comb begin
    tx     = gtl_pkg::xlat_lookup(in_byte_i);
    pend_d = PEND_NONE;
    rel    = 1'b0;
    use_tx = 1'b0;
    single = 1'b0;
    sch    = gtl_pkg::NUL;
    if (end_of_input_i) begin
      rel = 1'b1;
    end else if (in_byte_i == gtl_pkg::BYTE_N_LO) begin
      rel    = 1'b1;
      pend_d = PEND_N_LO;
    end else if (in_byte_i == gtl_pkg::BYTE_N_UP) begin
      rel    = 1'b1;
      pend_d = PEND_N_UP;
    end else if (in_byte_i == gtl_pkg::BYTE_M_LO) begin
      rel    = 1'b1;
      pend_d = PEND_M_LO;
    end else if (in_byte_i == gtl_pkg::BYTE_M_UP) begin
      rel    = 1'b1;
      pend_d = PEND_M_UP;
    end else if ((in_byte_i == gtl_pkg::BYTE_T_LO || in_byte_i == gtl_pkg::BYTE_T_UP) &&
                 (pend_q == PEND_N_LO || pend_q == PEND_N_UP)) begin
      single = 1'b1;
      sch    = (pend_q == PEND_N_LO) ? "d" : "D";
    end else if ((in_byte_i == gtl_pkg::BYTE_P_LO || in_byte_i == gtl_pkg::BYTE_P_UP) &&
                 (pend_q == PEND_M_LO || pend_q == PEND_M_UP)) begin
      single = 1'b1;
      sch    = (pend_q == PEND_M_LO) ? "b" : "B";
    end else begin
      rel    = 1'b1;
      use_tx = 1'b1;
    end
  end

  // Build the job: a merged letter alone, or the released letter first, then the table string
  always_comb begin
    relo = rel && has_p;
    tl   = use_tx ? tx.len : 2'd0;
    if (single) begin
      job.ch[0] = sch;
      job.ch[1] = gtl_pkg::NUL;
      job.ch[2] = gtl_pkg::NUL;
      job.ch[3] = gtl_pkg::NUL;
      job.cnt   = 3'd1;
    end else begin
      job.ch[0] = relo ? pch      : tx.ch[0];
      job.ch[1] = relo ? tx.ch[0] : tx.ch[1];
      job.ch[2] = relo ? tx.ch[1] : tx.ch[2];
      job.ch[3] = relo ? tx.ch[2] : gtl_pkg::NUL;
      job.cnt   = {2'b00, relo} + {1'b0, tl};
    end
  end

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign q_push_o   = accept && (job.cnt != 3'd0);
  assign q_job_o    = job;

  // Hold the pending letter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
    end else if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ===== src/gtl_queue.sv =====
// Two-entry job queue between front end and output sequencer.
// Depends on gtl_pkg for the job type.
module gtl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gtl_pkg::job_t push_job_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gtl_pkg::job_t pop_job_o
);

  gtl_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign ready_o   = (cnt_q != 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_job_o = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("job queue count out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("job queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("job queue pushed while full");

endmodule

// ===== src/gtl_back.sv =====
// Output sequencer: takes jobs from the queue and sends their characters
// one per cycle while the output is taken, through an output register. Depends on gtl_pkg.
module gtl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  gtl_pkg::job_t q_job_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          last_o
);

  gtl_pkg::job_t cur_q;
  logic          cur_vld_q;
  logic [1:0]    idx_q;
  logic          out_vld_q, last_q;
  logic [7:0]    char_q;
  logic          fire, fin;

  assign fire    = cur_vld_q && (!out_vld_q || out_ready_i);
  assign fin     = fire && ({1'b0, idx_q} == (cur_q.cnt - 3'd1));
  assign q_pop_o = q_valid_i && (!cur_vld_q || fin);

  assign out_valid_o = out_vld_q;
  assign out_char_o  = char_q;
  assign last_o      = last_q;

  // Hold the current job and step through its characters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= 2'd0;
    end else if (q_pop_o) begin
      cur_vld_q <= 1'b1;
      idx_q     <= 2'd0;
    end else if (fin) begin
      cur_vld_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end
  end

  // Load the output word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      char_q <= cur_q.ch[idx_q];
      last_q <= fin;
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (cur_q.cnt != 3'd0 && cur_q.cnt <= 3'd4))
    else $error("current job has no characters");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !fin) |=> (cur_vld_q && idx_q == $past(idx_q) + 2'd1))
    else $error("character index did not advance");

  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (cur_vld_q && idx_q == 2'd0))
    else $error("new job did not start at first character");

endmodule

// ===== src/greek_to_latin_transliterator_core.sv =====
// An accepted word passes the job queue, the current-job register and the output register.
// Throughput: one word per cycle while each yields at most one character and the output
// is taken; a word with more characters holds the output sequencer, four characters at worst.
// The front end keeps accepting while a two-entry job queue has room.
// Reset (rst_ni low, asynchronous) clears the held letter, the queue and the output.
module greek_to_latin_transliterator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_o
);

  gtl_pkg::job_t push_job, pop_job;
  logic          push, q_ready, q_valid, pop;

  gtl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_input_i(end_of_input_i),
    .q_ready_i     (q_ready),
    .q_push_o      (push),
    .q_job_o       (push_job)
  );

  gtl_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .ready_o   (q_ready),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .pop_job_o (pop_job)
  );

  gtl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (pop_job),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

endmodule

// ===== dv/gtl_translit_checker.sv =====
// Checker for the Greek-to-Latin transliterator: watches both channels,
// predicts the Latin characters of every accepted word and compares them.
// Depends on gtl_pkg for the byte codes of the letters that are held back.
module gtl_translit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic        last_i,
  output int unsigned errors_o,
  output int unsigned outstanding_o
);

  typedef enum logic [2:0] {
    HELD_NONE,
    HELD_N_LO,
    HELD_N_UP,
    HELD_M_LO,
    HELD_M_UP
  } held_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } latin_char_t;

  // Latin strings for bytes 182..254, right-justified, zero for holes
  logic [23:0] greek_str [73] = '{
    "'A", 24'd0, "'E", "'H", "'I", 24'd0, "'O", 24'd0, "'Y", "'W",
    "i\"'",
    "A", "V", "G", "D", "E", "Z", "H", "8", "I", "K", "L", "M", "N",
    "KS", "O", "P", "R",
    24'd0,
    "S", "T", "Y", "F", "X", "PS", "W",
    "I\"", "Y\"",
    "a'", "e'", "h'", "i'",
    "y\"'",
    "a", "v", "g", "d", "e", "z", "h", "8", "i", "k", "l", "m", "n",
    "ks", "o", "p", "r", "s", "s", "t", "y", "f", "x", "ps", "w",
    "i\"", "y\"",
    "o'", "y'", "w'"
  };

  held_e       held;
  latin_char_t latin_due [$];

  function automatic logic [7:0] held_char(held_e h);
    logic [7:0] c;
    case (h)
      HELD_N_LO: c = "n";
      HELD_N_UP: c = "N";
      HELD_M_LO: c = "m";
      default:   c = "M";
    endcase
    return c;
  endfunction

  // Work out the Latin characters of one word and queue them
  task automatic transliterate(input logic [7:0] b, input logic eoi);
    logic [7:0]  seq [4];
    logic [23:0] s;
    logic [6:0]  ix;
    int          n;
    int          len;
    held_e       nxt;
    logic        is_hold;
    logic        is_t;
    logic        is_p;
    n       = 0;
    nxt     = HELD_NONE;
    is_hold = (b == gtl_pkg::BYTE_N_LO) || (b == gtl_pkg::BYTE_N_UP) ||
              (b == gtl_pkg::BYTE_M_LO) || (b == gtl_pkg::BYTE_M_UP);
    is_t    = (b == gtl_pkg::BYTE_T_LO) || (b == gtl_pkg::BYTE_T_UP);
    is_p    = (b == gtl_pkg::BYTE_P_LO) || (b == gtl_pkg::BYTE_P_UP);
    if (!eoi && is_t && (held == HELD_N_LO || held == HELD_N_UP)) begin
      // merge n + t into d
      seq[0] = (held == HELD_N_LO) ? "d" : "D";
      n = 1;
    end else if (!eoi && is_p && (held == HELD_M_LO || held == HELD_M_UP)) begin
      // merge m + p into b
      seq[0] = (held == HELD_M_LO) ? "b" : "B";
      n = 1;
    end else begin
      // release the held letter first
      if (held != HELD_NONE) begin
        seq[0] = held_char(held);
        n = 1;
      end
      if (eoi) begin
        // flush only
      end else if (is_hold) begin
        case (b)
          gtl_pkg::BYTE_N_LO: nxt = HELD_N_LO;
          gtl_pkg::BYTE_N_UP: nxt = HELD_N_UP;
          gtl_pkg::BYTE_M_LO: nxt = HELD_M_LO;
          default:            nxt = HELD_M_UP;
        endcase
      end else if (b < gtl_pkg::TBL_BASE) begin
        seq[n] = b;
        n = n + 1;
      end else if (b != 8'd255) begin
        ix  = 7'(b - gtl_pkg::TBL_BASE);
        s   = greek_str[ix];
        len = (s[23:16] != 8'd0) ? 3 : (s[15:8] != 8'd0) ? 2 : (s[7:0] != 8'd0) ? 1 : 0;
        for (int k = 0; k < len; k++) begin
          seq[n] = s[8*(len-1-k) +: 8];
          n = n + 1;
        end
      end
    end
    held = nxt;
    for (int i = 0; i < n; i++) begin
      latin_due.push_back('{ch: seq[i], last: (i == n - 1)});
    end
  endtask

  // Predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    latin_char_t want;
    if (!rst_ni) begin
      held = HELD_NONE;
      latin_due.delete();
      errors_o = 0;
      outstanding_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        transliterate(in_byte_i, end_of_input_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (latin_due.size() == 0) begin
          errors_o = errors_o + 1;
          $display("%0t: unexpected word out_char 0x%02h last %0b", $time, out_char_i, last_i);
        end else begin
          want = latin_due.pop_front();
          if (out_char_i !== want.ch) begin
            errors_o = errors_o + 1;
            $display("%0t: out_char expected 0x%02h, got 0x%02h", $time, want.ch, out_char_i);
          end
          if (last_i !== want.last) begin
            errors_o = errors_o + 1;
            $display("%0t: last expected %0b, got %0b", $time, want.last, last_i);
          end
        end
      end
      outstanding_o = latin_due.size();
    end
  end

endmodule

// ===== dv/tb_greek_to_latin_transliterator_core.sv =====
// Testbench top for greek_to_latin_transliterator_core: drives directed and
// random ISO-8859-7 words under several idle and stall mixes and gives the verdict.
// Depends on gtl_pkg, the core and gtl_translit_checker.
module tb_greek_to_latin_transliterator_core;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_char_o;
  logic        last_o;

  int unsigned mismatches;
  int unsigned latin_pending;
  int unsigned words_sent;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  greek_to_latin_transliterator_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .last_o         (last_o)
  );

  gtl_translit_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_i     (out_char_o),
    .last_i         (last_o),
    .errors_o       (mismatches),
    .outstanding_o  (latin_pending)
  );

  // Stall the output side at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    in_byte_i      = b;
    end_of_input_i = eoi;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent = words_sent + 1;
    @(negedge clk_i);
  endtask

  // Held letters with their followers, plus Greek text, flushes and noise
  task automatic greek_burst();
    int unsigned pick;
    logic [7:0]  held_byte;
    pick = $urandom_range(99);
    if (pick < 35) begin
      case ($urandom_range(3))
        0:       held_byte = gtl_pkg::BYTE_N_LO;
        1:       held_byte = gtl_pkg::BYTE_N_UP;
        2:       held_byte = gtl_pkg::BYTE_M_LO;
        default: held_byte = gtl_pkg::BYTE_M_UP;
      endcase
      send_word(held_byte, 1'b0);
      case ($urandom_range(6))
        0:       send_word(gtl_pkg::BYTE_T_LO, 1'b0);
        1:       send_word(gtl_pkg::BYTE_T_UP, 1'b0);
        2:       send_word(gtl_pkg::BYTE_P_LO, 1'b0);
        3:       send_word(gtl_pkg::BYTE_P_UP, 1'b0);
        4:       send_word(8'($urandom_range(255)), 1'b1);
        default: send_word(8'($urandom_range(255)), 1'b0);
      endcase
    end else if (pick < 45) begin
      send_word(8'($urandom_range(255)), 1'b1);
    end else if (pick < 75) begin
      send_word(8'($urandom_range(255, 182)), 1'b0);
    end else begin
      send_word(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    int unsigned target;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target = words_sent + count;
    while (words_sent < target) greek_burst();
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    in_byte_i          = 8'd0;
    end_of_input_i     = 1'b0;
    out_ready_i        = 1'b0;
    words_sent         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Range edges, table holes and the longest strings
    send_word(8'd0, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd181, 1'b0);
    send_word(8'd182, 1'b0);
    send_word(8'd210, 1'b0);
    send_word(8'd254, 1'b0);
    send_word(8'd192, 1'b0);
    // Every merge of a held letter
    send_word(gtl_pkg::BYTE_N_LO, 1'b0);
    send_word(gtl_pkg::BYTE_T_LO, 1'b0);
    send_word(gtl_pkg::BYTE_N_UP, 1'b0);
    send_word(gtl_pkg::BYTE_T_UP, 1'b0);
    send_word(gtl_pkg::BYTE_M_LO, 1'b0);
    send_word(gtl_pkg::BYTE_P_LO, 1'b0);
    send_word(gtl_pkg::BYTE_M_UP, 1'b0);
    send_word(gtl_pkg::BYTE_P_UP, 1'b0);
    // Held letters followed by the wrong partner
    send_word(gtl_pkg::BYTE_N_LO, 1'b0);
    send_word(gtl_pkg::BYTE_P_LO, 1'b0);
    send_word(gtl_pkg::BYTE_M_LO, 1'b0);
    send_word(gtl_pkg::BYTE_T_UP, 1'b0);
    // Held letter replaced by another, then released by byte 255
    send_word(gtl_pkg::BYTE_N_LO, 1'b0);
    send_word(gtl_pkg::BYTE_N_UP, 1'b0);
    send_word(8'd255, 1'b0);
    // Release before a three-character string: four characters at once
    send_word(gtl_pkg::BYTE_M_LO, 1'b0);
    send_word(8'd192, 1'b0);
    // Release by a table hole
    send_word(gtl_pkg::BYTE_M_UP, 1'b0);
    send_word(8'd183, 1'b0);
    // Flush with and without a held letter
    send_word(gtl_pkg::BYTE_M_LO, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'd0, 1'b1);

    run_phase(0, 0, 64);
    run_phase(88, 0, 64);
    run_phase(0, 88, 64);
    run_phase(32, 32, 64);

    // Drain, then keep watching for stray words before the verdict
    in_valid_i = 1'b0;
    while (latin_pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatches == 0 && latin_pending == 0) begin
      $display("greek_to_latin_transliterator_core verification clean");
    end else begin
      $display("greek_to_latin_transliterator_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("greek_to_latin_transliterator_core verification failed");
    $finish;
  end

endmodule

// ===== greek_to_latin_transliterator_core.f =====
src/gtl_pkg.sv
src/gtl_front.sv
src/gtl_queue.sv
src/gtl_back.sv
src/greek_to_latin_transliterator_core.sv
dv/gtl_translit_checker.sv
dv/tb_greek_to_latin_transliterator_core.sv
